// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== rtl/hcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// hcfe_pkg
// Types, widths and helpers shared by the handle cache eviction unit.
// ----------------------------------------------------------------------------
package hcfe_pkg;

	localparam int KEY_W       = 32;
	localparam int HND_W       = 32;
	localparam int AGE_W       = 32;
	localparam int ENTRIES_DEF = 8;

	typedef enum logic [1:0] {
		KIND_GET   = 2'd0,
		KIND_PUT   = 2'd1,
		KIND_DROP  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HND_W-1:0] hnd;
		logic [AGE_W-1:0] age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic key_eq;
		logic age_lt;
	} cmp_t;

	typedef struct packed {
		logic             found;
		logic [HND_W-1:0] taken_handle;
		logic             freed_valid;
		logic [HND_W-1:0] freed_handle;
		logic             last;
	} res_t;

	function automatic res_t mk_res(input logic found, input logic [HND_W-1:0] taken,
			input logic fvalid, input logic [HND_W-1:0] fhnd, input logic last);
		res_t r;
		r.found        = found;
		r.taken_handle = taken;
		r.freed_valid  = fvalid;
		r.freed_handle = fhnd;
		r.last         = last;
		return r;
	endfunction

endpackage

// ===== rtl/hcfe_ram.sv =====
// ----------------------------------------------------------------------------
// hcfe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hcfe_ram #(
	parameter int WIDTH = hcfe_pkg::ENTRY_W,
	parameter int DEPTH = hcfe_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/hcfe_cmp.sv =====
// ----------------------------------------------------------------------------
// hcfe_cmp
// Shared compare unit: key equality and unsigned age less-than.
// ----------------------------------------------------------------------------
module hcfe_cmp (
	input  logic [hcfe_pkg::KEY_W-1:0] key_a,
	input  logic [hcfe_pkg::KEY_W-1:0] key_b,
	input  logic [hcfe_pkg::AGE_W-1:0] age_a,
	input  logic [hcfe_pkg::AGE_W-1:0] age_b,
	output hcfe_pkg::cmp_t             res
);

	assign res.key_eq = (key_a == key_b);
	assign res.age_lt = (age_a < age_b);

endmodule

// ===== rtl/hcfe_seq.sv =====
// ----------------------------------------------------------------------------
// hcfe_seq
// Sequencer: scans the entry RAM one slot per cycle and issues results.
// ----------------------------------------------------------------------------
module hcfe_seq #(
	parameter int ENTRIES = hcfe_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          kind,
	input  logic [hcfe_pkg::KEY_W-1:0]          key,
	input  logic [hcfe_pkg::HND_W-1:0]          handle,
	output logic                                busy,
	output logic                                result_valid,
	output hcfe_pkg::res_t                      res,
	output logic                                rd_en,
	output logic [$clog2(ENTRIES)-1:0]          rd_addr,
	input  logic [hcfe_pkg::ENTRY_W-1:0]        rd_data,
	output logic                                wr_en,
	output logic [$clog2(ENTRIES)-1:0]          wr_addr,
	output logic [hcfe_pkg::ENTRY_W-1:0]        wr_data,
	output logic [hcfe_pkg::KEY_W-1:0]          cmp_key_a,
	output logic [hcfe_pkg::KEY_W-1:0]          cmp_key_b,
	output logic [hcfe_pkg::AGE_W-1:0]          cmp_age_a,
	output logic [hcfe_pkg::AGE_W-1:0]          cmp_age_b,
	input  hcfe_pkg::cmp_t                      cmp_res
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_FLUSH
	} state_t;

	state_t                       state_q;
	hcfe_pkg::kind_t              kind_q;
	logic [hcfe_pkg::KEY_W-1:0]   key_q;
	logic [hcfe_pkg::HND_W-1:0]   hnd_q;
	logic [IDX_W-1:0]             rd_idx_q;
	logic                         iss_q;
	logic                         chk_vld_s1;
	logic [IDX_W-1:0]             chk_idx_s1;
	logic [ENTRIES-1:0]           valid_q;
	logic [hcfe_pkg::AGE_W-1:0]   best_age_q;
	logic [hcfe_pkg::HND_W-1:0]   best_hnd_q;
	logic [IDX_W-1:0]             slot_q;
	logic                         evict_q;
	logic                         pend_q;
	logic [hcfe_pkg::HND_W-1:0]   pend_hnd_q;
	logic [hcfe_pkg::AGE_W-1:0]   ctr_q;
	logic                         res_vld_q;
	hcfe_pkg::res_t               res_q;

	hcfe_pkg::entry_t             ent;
	hcfe_pkg::entry_t             new_ent;
	logic                         cur_valid;
	logic                         last_ent;
	logic                         match;

	assign ent       = hcfe_pkg::entry_t'(rd_data);
	assign cur_valid = valid_q[chk_idx_s1];
	assign last_ent  = (chk_idx_s1 == LAST_IDX);
	assign match     = cur_valid && ((kind_q == hcfe_pkg::KIND_CLEAR) || cmp_res.key_eq);

	assign cmp_key_a = ent.key;
	assign cmp_key_b = key_q;
	assign cmp_age_a = ent.age;
	assign cmp_age_b = best_age_q;

	assign rd_en   = (state_q == S_SCAN) && iss_q;
	assign rd_addr = rd_idx_q;

	always_comb begin
		new_ent.key = key_q;
		new_ent.hnd = hnd_q;
		new_ent.age = ctr_q + 1'b1;
	end

	assign wr_en   = (state_q == S_WRITE);
	assign wr_addr = slot_q;
	assign wr_data = new_ent;

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_vld_q;
	assign res          = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= hcfe_pkg::KIND_GET;
			key_q      <= '0;
			hnd_q      <= '0;
			rd_idx_q   <= '0;
			iss_q      <= 1'b0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			valid_q    <= '0;
			best_age_q <= '0;
			best_hnd_q <= '0;
			slot_q     <= '0;
			evict_q    <= 1'b0;
			pend_q     <= 1'b0;
			pend_hnd_q <= '0;
			ctr_q      <= '0;
			res_vld_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			res_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q     <= hcfe_pkg::kind_t'(kind);
						key_q      <= key;
						hnd_q      <= handle;
						rd_idx_q   <= '0;
						iss_q      <= 1'b1;
						chk_vld_s1 <= 1'b0;
						pend_q     <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					// advance the read side of the scan
					chk_vld_s1 <= iss_q;
					chk_idx_s1 <= rd_idx_q;
					if (iss_q) begin
						if (rd_idx_q == LAST_IDX) begin
							iss_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (chk_vld_s1) begin
						case (kind_q)
							hcfe_pkg::KIND_GET: begin
								if (cur_valid && cmp_res.key_eq) begin
									valid_q[chk_idx_s1] <= 1'b0;
									res_vld_q  <= 1'b1;
									res_q      <= hcfe_pkg::mk_res(1'b1, ent.hnd, 1'b0, '0, 1'b1);
									iss_q      <= 1'b0;
									chk_vld_s1 <= 1'b0;
									state_q    <= S_IDLE;
								end else if (last_ent) begin
									res_vld_q  <= 1'b1;
									res_q      <= hcfe_pkg::mk_res(1'b0, '0, 1'b0, '0, 1'b1);
									iss_q      <= 1'b0;
									chk_vld_s1 <= 1'b0;
									state_q    <= S_IDLE;
								end
							end
							hcfe_pkg::KIND_PUT: begin
								if (!cur_valid) begin
									slot_q     <= chk_idx_s1;
									evict_q    <= 1'b0;
									iss_q      <= 1'b0;
									chk_vld_s1 <= 1'b0;
									state_q    <= S_WRITE;
								end else begin
									// track oldest; ties keep the lower slot
									if (chk_idx_s1 == '0 || cmp_res.age_lt) begin
										best_age_q <= ent.age;
										best_hnd_q <= ent.hnd;
										slot_q     <= chk_idx_s1;
									end
									if (last_ent) begin
										evict_q    <= 1'b1;
										chk_vld_s1 <= 1'b0;
										state_q    <= S_WRITE;
									end
								end
							end
							default: begin
								// hold one freed handle back so last can be marked
								if (match) begin
									valid_q[chk_idx_s1] <= 1'b0;
									pend_q     <= 1'b1;
									pend_hnd_q <= ent.hnd;
									if (pend_q) begin
										res_vld_q <= 1'b1;
										res_q     <= hcfe_pkg::mk_res(1'b0, '0, 1'b1,
											pend_hnd_q, 1'b0);
									end
								end
								if (last_ent) begin
									chk_vld_s1 <= 1'b0;
									state_q    <= S_FLUSH;
								end
							end
						endcase
					end
				end
				S_WRITE: begin
					ctr_q           <= ctr_q + 1'b1;
					valid_q[slot_q] <= (hnd_q != '0);
					res_vld_q       <= 1'b1;
					res_q           <= hcfe_pkg::mk_res(1'b0, '0, evict_q,
						evict_q ? best_hnd_q : '0, 1'b1);
					state_q         <= S_IDLE;
				end
				S_FLUSH: begin
					res_vld_q <= 1'b1;
					res_q     <= hcfe_pkg::mk_res(1'b0, '0, pend_q,
						pend_q ? pend_hnd_q : '0, 1'b1);
					pend_q    <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/handle_cache_fifo_evict_unit.sv =====
// ----------------------------------------------------------------------------
// handle_cache_fifo_evict_unit
// Fully associative handle pool with get, put (oldest-insert eviction),
// drop by key and clear.
//
//   channel   handshake                 payload
//   request   start / busy              kind, key, handle
//   result    result_valid (strobe)     found, taken_handle, freed_valid,
//                                       freed_handle, last
//
// A request is taken when start is high and busy is low; busy stays high
// until its final result has been issued. The entry RAM is scanned one slot
// per cycle through its single read port; get stops at the first match,
// put at the first free slot; drop and clear scan all. Each result shows for one
// cycle and cannot be stalled. Reset clears all valid bits and the age counter.
// ----------------------------------------------------------------------------
module handle_cache_fifo_evict_unit #(
	parameter int ENTRIES = hcfe_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [hcfe_pkg::KEY_W-1:0] key,
	input  logic [hcfe_pkg::HND_W-1:0] handle,
	output logic                       result_valid,
	output logic                       found,
	output logic [hcfe_pkg::HND_W-1:0] taken_handle,
	output logic                       freed_valid,
	output logic [hcfe_pkg::HND_W-1:0] freed_handle,
	output logic                       last
);

	localparam int IDX_W = $clog2(ENTRIES);

	hcfe_pkg::res_t               res;
	logic                         rd_en;
	logic [IDX_W-1:0]             rd_addr;
	logic [hcfe_pkg::ENTRY_W-1:0] rd_data;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	logic [hcfe_pkg::ENTRY_W-1:0] wr_data;
	logic [hcfe_pkg::KEY_W-1:0]   cmp_key_a;
	logic [hcfe_pkg::KEY_W-1:0]   cmp_key_b;
	logic [hcfe_pkg::AGE_W-1:0]   cmp_age_a;
	logic [hcfe_pkg::AGE_W-1:0]   cmp_age_b;
	hcfe_pkg::cmp_t               cmp_res;

	hcfe_seq #(
		.ENTRIES(ENTRIES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.key         (key),
		.handle      (handle),
		.busy        (busy),
		.result_valid(result_valid),
		.res         (res),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.cmp_key_a   (cmp_key_a),
		.cmp_key_b   (cmp_key_b),
		.cmp_age_a   (cmp_age_a),
		.cmp_age_b   (cmp_age_b),
		.cmp_res     (cmp_res)
	);

	hcfe_ram #(
		.WIDTH(hcfe_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	hcfe_cmp u_cmp (
		.key_a(cmp_key_a),
		.key_b(cmp_key_b),
		.age_a(cmp_age_a),
		.age_b(cmp_age_b),
		.res  (cmp_res)
	);

	assign found        = res.found;
	assign taken_handle = res.taken_handle;
	assign freed_valid  = res.freed_valid;
	assign freed_handle = res.freed_handle;
	assign last         = res.last;

endmodule

// ===== rtl/hcfe_chk.sv =====
// ----------------------------------------------------------------------------
// hcfe_chk
// Port-level checks for the handle cache eviction unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcfe_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic                       found,
	input logic [hcfe_pkg::HND_W-1:0] taken_handle,
	input logic                       freed_valid,
	input logic [hcfe_pkg::HND_W-1:0] freed_handle,
	input logic                       last
);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NOW(a_last_idle, clk, arst_n, result_valid && last, !busy)
	`ASSERT_NOW(a_idle_only_last, clk, arst_n, result_valid && !busy, last)
	`ASSERT_NOW(a_found_no_free, clk, arst_n, result_valid && found, !freed_valid)
	`ASSERT_NOW(a_free_zero, clk, arst_n, result_valid && !freed_valid, freed_handle == '0)

endmodule

bind handle_cache_fifo_evict_unit hcfe_chk u_hcfe_chk (.*);
